>>> rtl/dccs_pkg.sv
// Package for the drift-compensated clock sync block.
// Item types, fixed-point constants and shared-adder control type.
// No dependencies.
package dccs_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int TIME_W      = 32;
  localparam int WEIGHT_W    = 16;
  localparam int ALU_W       = TIME_W + 2;
  localparam int CNT_W       = 5;
  localparam int DIV_STEPS   = TIME_W;
  localparam int MUL_STEPS   = TIME_W;
  localparam int BLEND_STEPS = WEIGHT_W;

  localparam logic [TIME_W-1:0]   DRIFT_ONE    = TIME_W'(64'd1 << FRAC_BITS);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;

  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_SYNC = 1'b1;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] local_time;
    logic [TIME_W-1:0] master_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] corrected_time;
    logic [TIME_W-1:0] drift_now;
  } out_item_t;

  typedef struct packed {
    logic sub;
    logic cin;
  } alu_ctl_t;

endpackage

>>> rtl/dccs_alu.sv
// Shared add/subtract unit of the clock sync block.
// Depends on dccs_pkg for widths and the control struct.
module dccs_alu (
  input  logic [dccs_pkg::ALU_W-1:0] a,
  input  logic [dccs_pkg::ALU_W-1:0] b,
  input  dccs_pkg::alu_ctl_t         ctl,
  output logic [dccs_pkg::ALU_W-1:0] sum
);

  logic [dccs_pkg::ALU_W-1:0] b_eff;
  logic [dccs_pkg::ALU_W-1:0] carry_in;

  assign b_eff    = ctl.sub ? ~b : b;
  assign carry_in = dccs_pkg::ALU_W'(ctl.sub | ctl.cin);
  assign sum      = a + b_eff + carry_in;

endmodule

>>> rtl/drift_compensated_clock_sync.sv
// Top level of the drift-compensated follower clock.
// Sequencer and registers around one shared adder (dccs_alu); uses dccs_pkg.
//
//   port group | direction | handshake           | payload
//   in_        | input     | in_valid / in_stall   | dccs_pkg::in_item_t
//   out_       | output    | out_valid / out_stall | dccs_pkg::out_item_t
//   cfg_       | input     | cfg_valid / cfg_ready | smoothing weight, Q0.16
//
// A read forms the elapsed-times-drift product in 32 shift-add steps of the
// shared adder. A sync with no drift update due skips to the anchors; when
// the ratio saturates the divide is skipped, else 32 restoring divide steps
// and 16 weighting steps run, all on the one adder. One item is in work at
// a time; the result register lets the next item enter while a result waits.
// Reset (rst_n, synchronous) sets drift to 1.0 and clears the anchors.
module drift_compensated_clock_sync (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dccs_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dccs_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dccs_pkg::WEIGHT_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ELAPSED,
    S_MASTER,
    S_SATCHK,
    S_DIV,
    S_DIFF,
    S_BLEND,
    S_ROUND,
    S_MUL,
    S_CORRECT,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t                           state_r, state_nxt;
  dccs_pkg::in_item_t               item_r, item_nxt;
  logic [dccs_pkg::ALU_W-1:0]       hi_r, hi_nxt;
  logic [dccs_pkg::TIME_W-1:0]      lo_r, lo_nxt;
  logic [dccs_pkg::ALU_W-1:0]       mcand_r, mcand_nxt;
  logic [dccs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [dccs_pkg::TIME_W-1:0]      drift_r, drift_nxt;
  logic [dccs_pkg::TIME_W-1:0]      lanchor_r, lanchor_nxt;
  logic [dccs_pkg::TIME_W-1:0]      manchor_r, manchor_nxt;
  logic                             avalid_r, avalid_nxt;
  logic [dccs_pkg::WEIGHT_W-1:0]    weight_r, weight_nxt;
  logic [dccs_pkg::TIME_W-1:0]      corr_r, corr_nxt;
  logic                             out_valid_r, out_valid_nxt;
  dccs_pkg::out_item_t              out_item_r, out_item_nxt;

  logic [dccs_pkg::ALU_W-1:0]       alu_a, alu_b, alu_sum;
  dccs_pkg::alu_ctl_t               alu_ctl;
  logic [dccs_pkg::ALU_W-1:0]       rem_shift;
  logic [2*dccs_pkg::TIME_W-1:0]    prod;
  logic [dccs_pkg::TIME_W-1:0]      res32;

  dccs_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .ctl (alu_ctl),
    .sum (alu_sum)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign rem_shift = {hi_r[dccs_pkg::ALU_W-2:0], lo_r[dccs_pkg::TIME_W-1]};
  assign prod      = {hi_r[dccs_pkg::TIME_W-1:0], lo_r};
  assign res32     = alu_sum[dccs_pkg::TIME_W-1:0];

  always_comb begin
    alu_a   = hi_r;
    alu_b   = lo_r[0] ? mcand_r : '0;
    alu_ctl = '{sub: 1'b0, cin: 1'b0};
    case (state_r)
      S_ELAPSED: begin
        alu_a   = dccs_pkg::ALU_W'(item_r.local_time);
        alu_b   = dccs_pkg::ALU_W'(lanchor_r);
        alu_ctl = '{sub: 1'b1, cin: 1'b0};
      end
      S_MASTER: begin
        alu_a   = dccs_pkg::ALU_W'(item_r.master_time);
        alu_b   = dccs_pkg::ALU_W'(manchor_r);
        alu_ctl = '{sub: 1'b1, cin: 1'b0};
      end
      S_SATCHK: begin
        alu_b   = mcand_r;
        alu_ctl = '{sub: 1'b1, cin: 1'b0};
      end
      S_DIV: begin
        alu_a   = rem_shift;
        alu_b   = mcand_r;
        alu_ctl = '{sub: 1'b1, cin: 1'b0};
      end
      S_DIFF: begin
        alu_a   = dccs_pkg::ALU_W'(lo_r);
        alu_b   = dccs_pkg::ALU_W'(drift_r);
        alu_ctl = '{sub: 1'b1, cin: 1'b0};
      end
      S_ROUND: begin
        alu_a   = dccs_pkg::ALU_W'(drift_r);
        alu_b   = hi_r;
        alu_ctl = '{sub: 1'b0, cin: lo_r[dccs_pkg::TIME_W-1]};
      end
      S_CORRECT: begin
        alu_a   = dccs_pkg::ALU_W'(manchor_r);
        alu_b   = dccs_pkg::ALU_W'(prod[dccs_pkg::FRAC_BITS +: dccs_pkg::TIME_W]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    mcand_nxt     = mcand_r;
    cnt_nxt       = cnt_r;
    drift_nxt     = drift_r;
    lanchor_nxt   = lanchor_r;
    manchor_nxt   = manchor_r;
    avalid_nxt    = avalid_r;
    weight_nxt    = weight_r;
    corr_nxt      = corr_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (cfg_valid && cfg_ready) begin
      weight_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_ELAPSED;
        end
      end
      S_ELAPSED: begin
        if (item_r.action == dccs_pkg::ACT_READ) begin
          hi_nxt    = '0;
          lo_nxt    = res32;
          mcand_nxt = dccs_pkg::ALU_W'(drift_r);
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else if (!avalid_r || (res32 == '0)) begin
          state_nxt = S_UPDATE;
        end else begin
          mcand_nxt = dccs_pkg::ALU_W'(res32);
          state_nxt = S_MASTER;
        end
      end
      S_MASTER: begin
        hi_nxt    = dccs_pkg::ALU_W'(res32 >> (dccs_pkg::TIME_W - dccs_pkg::FRAC_BITS));
        lo_nxt    = res32 << dccs_pkg::FRAC_BITS;
        state_nxt = S_SATCHK;
      end
      S_SATCHK: begin
        cnt_nxt = '0;
        if (!alu_sum[dccs_pkg::ALU_W-1]) begin
          lo_nxt    = '1;
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        hi_nxt  = alu_sum[dccs_pkg::ALU_W-1] ? rem_shift : alu_sum;
        lo_nxt  = {lo_r[dccs_pkg::TIME_W-2:0], ~alu_sum[dccs_pkg::ALU_W-1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == dccs_pkg::CNT_W'(dccs_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        mcand_nxt = alu_sum;
        hi_nxt    = '0;
        lo_nxt    = dccs_pkg::TIME_W'(weight_r);
        cnt_nxt   = '0;
        state_nxt = S_BLEND;
      end
      S_BLEND, S_MUL: begin
        hi_nxt  = {alu_sum[dccs_pkg::ALU_W-1], alu_sum[dccs_pkg::ALU_W-1:1]};
        lo_nxt  = {alu_sum[0], lo_r[dccs_pkg::TIME_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if ((state_r == S_BLEND) &&
            (cnt_r == dccs_pkg::CNT_W'(dccs_pkg::BLEND_STEPS - 1))) begin
          state_nxt = S_ROUND;
        end
        if ((state_r == S_MUL) &&
            (cnt_r == dccs_pkg::CNT_W'(dccs_pkg::MUL_STEPS - 1))) begin
          state_nxt = S_CORRECT;
        end
      end
      S_ROUND: begin
        drift_nxt = res32;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        lanchor_nxt = item_r.local_time;
        manchor_nxt = item_r.master_time;
        avalid_nxt  = 1'b1;
        corr_nxt    = item_r.master_time;
        state_nxt   = S_DONE;
      end
      S_CORRECT: begin
        corr_nxt  = res32;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt  = '{corrected_time: corr_r, drift_now: drift_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    mcand_r    <= mcand_nxt;
    cnt_r      <= cnt_nxt;
    corr_r     <= corr_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      drift_r     <= dccs_pkg::DRIFT_ONE;
      lanchor_r   <= '0;
      manchor_r   <= '0;
      avalid_r    <= 1'b0;
      weight_r    <= dccs_pkg::WEIGHT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drift_r     <= drift_nxt;
      lanchor_r   <= lanchor_nxt;
      manchor_r   <= manchor_nxt;
      avalid_r    <= avalid_nxt;
      weight_r    <= weight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> dv/dccs_sync_checker.sv
// Scoreboard for drift_compensated_clock_sync: watches the item, result and weight channels.
// Keeps its own copy of anchors, drift and weight, predicts each result, compares in order.
// Depends on dccs_pkg for the item types and fixed-point constants.
module dccs_sync_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  dccs_pkg::in_item_t            in_item,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  dccs_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dccs_pkg::WEIGHT_W-1:0] cfg_data,
  output int                            mismatch_count
);
  import dccs_pkg::*;

  logic [TIME_W-1:0]   local_ref;
  logic [TIME_W-1:0]   master_ref;
  logic [TIME_W-1:0]   drift;
  logic                synced;
  logic [WEIGHT_W-1:0] weight;
  out_item_t           due_readings[$];

  function automatic out_item_t follow_master(input in_item_t it);
    logic [TIME_W-1:0] local_gap;
    logic [TIME_W-1:0] master_gap;
    logic [TIME_W-1:0] since_anchor;
    logic [63:0]       ratio;
    logic [63:0]       mix;
    logic [63:0]       scaled;
    out_item_t         res;
    if (it.action == ACT_SYNC) begin
      if (synced) begin
        local_gap  = it.local_time - local_ref;
        master_gap = it.master_time - master_ref;
        if (local_gap != '0) begin
          ratio = ({32'd0, master_gap} << FRAC_BITS) / {32'd0, local_gap};
          if (ratio > 64'h0000_0000_FFFF_FFFF)
            ratio = 64'h0000_0000_FFFF_FFFF;
          mix = ratio * {48'd0, weight}
              + (64'd65536 - {48'd0, weight}) * {32'd0, drift}
              + 64'd32768;
          drift = mix[47:16];
        end
      end
      local_ref  = it.local_time;
      master_ref = it.master_time;
      synced     = 1'b1;
    end
    since_anchor       = it.local_time - local_ref;
    scaled             = {32'd0, since_anchor} * {32'd0, drift};
    res.corrected_time = master_ref + scaled[FRAC_BITS +: TIME_W];
    res.drift_now      = drift;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      local_ref      = '0;
      master_ref     = '0;
      drift          = DRIFT_ONE;
      synced         = 1'b0;
      weight         = WEIGHT_RESET;
      mismatch_count = 0;
      due_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_item);
          mismatch_count++;
        end else begin
          want = due_readings.pop_front();
          if (out_item.corrected_time !== want.corrected_time) begin
            $display("%0t: corrected_time expected %h actual %h", $time,
                     want.corrected_time, out_item.corrected_time);
            mismatch_count++;
          end
          if (out_item.drift_now !== want.drift_now) begin
            $display("%0t: drift_now expected %h actual %h", $time,
                     want.drift_now, out_item.drift_now);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        weight = cfg_data;
      if (in_valid && !in_stall)
        due_readings.push_back(follow_master(in_item));
    end
  end

endmodule

>>> dv/tb.sv
// Top of the drift_compensated_clock_sync testbench: clock, reset, item and weight stimulus.
// Checking is done by dccs_sync_checker beside the block; this module gives the verdict.
// Depends on dccs_pkg, dccs_sync_checker and the block itself.
module tb;
  import dccs_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_ITEMS  = 260;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 100;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WEIGHT_W-1:0] cfg_data  = '0;
  int                  in_count    = 0;
  int                  out_count   = 0;
  int                  idle_cycles = 0;
  int                  mismatches;
  logic                quiet;

  assign quiet = (in_count >= 560) && (in_count < 790);

  drift_compensated_clock_sync dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dccs_sync_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        in_count <= in_count + 1;
      if (out_valid && !out_stall)
        out_count <= out_count + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // hold off once for a long stretch so the block backs up into its input
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && in_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  task automatic offer_item(input logic act, input logic [TIME_W-1:0] lt,
                            input logic [TIME_W-1:0] mt);
    in_item_t it;
    it.action      = act;
    it.local_time  = lt;
    it.master_time = mt;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_count != out_count);
  endtask

  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    drain();
    cfg_data  <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                n;
    int                roll;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] true_local;
    logic [TIME_W-1:0] true_master;
    logic [TIME_W-1:0] last_sync_local;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads before any sync, first sync, zero interval, saturation, zero ratio, wrap
    offer_item(ACT_READ, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_item(ACT_READ, 32'hFFFF_FFFF, 32'h0000_0000);
    offer_item(ACT_READ, 32'h1234_5678, 32'h8765_4321);
    offer_item(ACT_SYNC, 32'd1000, 32'd5000);
    offer_item(ACT_READ, 32'd1500, 32'hFFFF_FFFF);
    offer_item(ACT_SYNC, 32'd1000, 32'd9000);
    offer_item(ACT_SYNC, 32'd2000, 32'd10100);
    offer_item(ACT_SYNC, 32'd2001, 32'hFFFF_FFFF);
    offer_item(ACT_READ, 32'hFFFF_FFFF, 32'h0000_0000);
    offer_item(ACT_SYNC, 32'd3001, 32'hFFFF_FFFF);
    offer_item(ACT_SYNC, 32'hFFFF_FF00, 32'hFFFF_FFF0);
    offer_item(ACT_READ, 32'h0000_0100, 32'h5555_5555);
    offer_item(ACT_SYNC, 32'h0000_0200, 32'h0000_0300);
    offer_item(ACT_SYNC, 32'h0000_01FF, 32'h1234_5678);
    set_weight(16'hFFFF);
    offer_item(ACT_SYNC, 32'h0000_1200, 32'h0000_1400);
    offer_item(ACT_SYNC, 32'h0000_2200, 32'h0000_2000);
    offer_item(ACT_READ, 32'h0000_2A00, 32'hAAAA_AAAA);
    set_weight(16'h0000);
    offer_item(ACT_SYNC, 32'h0000_3200, 32'h0000_9000);
    offer_item(ACT_READ, 32'h8000_0000, 32'h0000_0000);

    true_local      = 32'h0000_3200;
    true_master     = 32'h0000_9000;
    last_sync_local = true_local;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case (n / PHASE_ITEMS)
          0: set_weight(16'hFFFF);
          1: set_weight(16'h0000);
          3: set_weight(16'h0001);
          4: set_weight(WEIGHT_RESET);
          default: set_weight(16'($urandom_range(65535)));
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 80) begin
        step = ($urandom_range(49) == 0) ? $urandom : $urandom_range(0, 3000);
        true_local  = true_local + step;
        true_master = true_master + step + $urandom_range(0, step >> 5) - (step >> 6);
        if ($urandom_range(99) < 35) begin
          offer_item(ACT_SYNC, true_local, true_master);
          last_sync_local = true_local;
        end else begin
          offer_item(ACT_READ, true_local, $urandom);
        end
      end else if (roll < 88) begin
        offer_item(ACT_SYNC, last_sync_local, $urandom);
      end else begin
        step = $urandom;
        offer_item(1'($urandom), step, $urandom);
        if (in_item.action == ACT_SYNC)
          last_sync_local = step;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && in_count == out_count)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
